FILE: hw/rtl/csa_pkg.sv
// Shared types, register codes and helpers of the collective segment aggregator.
package csa_pkg;

    localparam int unsigned DEF_MAX_GPUS      = 8;
    localparam int unsigned DEF_TABLE_ENTRIES = 16;

    // GPU count width: holds up to 127
    localparam int unsigned CNT_W = 7;

    localparam logic [7:0] KIND_CONTRIB = 8'd1;

    localparam logic [1:0] CFG_NUM_GPU     = 2'd0;
    localparam logic [1:0] CFG_MAGIC_WORD  = 2'd1;
    localparam logic [1:0] CFG_SWITCH_ID   = 2'd2;
    localparam logic [1:0] CFG_SOURCE_NODE = 2'd3;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [7:0]  src_gpu;
        logic [31:0] group;
        logic [63:0] collective_id;
        logic [63:0] segment_id;
        logic [31:0] num_segments;
        logic [31:0] segment_bytes;
    } t_item;

    // Saturate the programmed GPU count to the hardware limit
    function automatic logic [CNT_W-1:0] eff_gpu(input logic [3:0] num,
                                                 input int unsigned max_gpus);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(max_gpus);
        if (CNT_W'(num) > lim) begin
            return lim;
        end
        return CNT_W'(num);
    endfunction

endpackage

FILE: hw/rtl/csa_front.sv
// Front end: header checks and a two-deep queue of accepted contributions.
module csa_front
    import csa_pkg::*;
#(
    parameter int unsigned MAX_GPUS = DEF_MAX_GPUS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_short_payload,
    input  logic [31:0] i_magic,
    input  logic [7:0]  i_kind,
    input  t_item       i_item,
    input  logic [3:0]  i_num_gpu,
    input  logic [31:0] i_magic_word,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep, acc, wr, rd;

    // Drop short, foreign, wrong-kind and out-of-range headers
    assign keep = !i_short_payload && (i_magic == i_magic_word) &&
                  (i_kind == KIND_CONTRIB) &&
                  ({1'b0, i_item.src_gpu} < 9'(eff_gpu(i_num_gpu, MAX_GPUS)));

    assign o_full    = (r_cnt == 2'd2);
    assign acc       = i_push && !o_full;
    assign wr        = acc && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign rd        = o_q_valid && i_q_pop;
    assign o_q_item  = r_q[r_rp];

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_item;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

FILE: hw/rtl/csa_back.sv
// Back end: key table scan, entry update, completion fan-out and table-full replies.
module csa_back
    import csa_pkg::*;
#(
    parameter int unsigned MAX_GPUS      = DEF_MAX_GPUS,
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_num_gpu,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_status,
    output logic [2:0]  o_dest_gpu,
    output logic [31:0] o_group_out,
    output logic [63:0] o_collective_out,
    output logic [63:0] o_segment_out,
    output logic [31:0] o_num_segments_out,
    output logic [31:0] o_segment_bytes_out,
    output logic        o_last
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned SW = (MAX_GPUS > 1) ? $clog2(MAX_GPUS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    typedef struct packed {
        logic [31:0]         group;
        logic [63:0]         collective_id;
        logic [63:0]         segment_id;
        logic [MAX_GPUS-1:0] mask;
        logic [CNT_W-1:0]    count;
        logic [31:0]         seg_bytes;
        logic [31:0]         num_segments;
    } t_entry;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [2:0]       r_state;
    t_item            r_item;
    logic [IW-1:0]    r_idx, r_cmp_idx, r_hit_idx, r_free_idx;
    logic             r_cmp_vld, r_hit_vld, r_free_vld;
    logic [MAX_GPUS-1:0] r_hit_mask;
    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_n, r_g;
    logic             r_status;
    logic             r_out_vld;

    logic [CNT_W-1:0]    eff;
    logic [MAX_GPUS-1:0] src_bit, new_mask;
    logic [CNT_W-1:0]    new_cnt;
    logic                match, ld, last_now;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    t_entry              wr_ent;

    assign eff      = eff_gpu(i_num_gpu, MAX_GPUS);
    assign src_bit  = MAX_GPUS'(1) << r_item.src_gpu[SW-1:0];
    assign new_mask = r_hit_mask | src_bit;
    assign new_cnt  = ((r_hit_mask & src_bit) == '0) ? r_hit_cnt + CNT_W'(1) : r_hit_cnt;
    assign match    = (r_rdata.group == r_item.group) &&
                      (r_rdata.collective_id == r_item.collective_id) &&
                      (r_rdata.segment_id == r_item.segment_id);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign ld       = (r_state == S_EMIT) && (!r_out_vld || i_pop);
    assign last_now = (r_g + CNT_W'(1) == r_n);
    assign o_empty  = !r_out_vld;

    // Build the entry write of the decide step
    always_comb begin
        wr_en  = 1'b0;
        wr_idx = r_free_idx;
        wr_ent.group         = r_item.group;
        wr_ent.collective_id = r_item.collective_id;
        wr_ent.segment_id    = r_item.segment_id;
        wr_ent.mask          = src_bit;
        wr_ent.count         = CNT_W'(1);
        wr_ent.seg_bytes     = r_item.segment_bytes;
        wr_ent.num_segments  = r_item.num_segments;
        if (r_state == S_DEC) begin
            if (r_hit_vld) begin
                wr_en        = 1'b1;
                wr_idx       = r_hit_idx;
                wr_ent.mask  = new_mask;
                wr_ent.count = new_cnt;
            end else if (eff > CNT_W'(1) && r_free_vld) begin
                wr_en = 1'b1;
            end
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_ent;
        end
        r_rdata <= r_mem[r_idx];
    end

    // Hold the item and the scan findings
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        r_cmp_idx <= r_idx;
        if (r_cmp_vld && r_valid[r_cmp_idx] && match && !r_hit_vld) begin
            r_hit_idx  <= r_cmp_idx;
            r_hit_mask <= r_rdata.mask;
            r_hit_cnt  <= r_rdata.count;
        end
        if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_vld) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (ld) begin
            o_status            <= r_status;
            o_dest_gpu          <= (r_status == STATUS_FULL) ? r_item.src_gpu[2:0] : r_g[2:0];
            o_group_out         <= r_item.group;
            o_collective_out    <= r_item.collective_id;
            o_segment_out       <= r_item.segment_id;
            o_num_segments_out  <= r_item.num_segments;
            o_segment_bytes_out <= r_item.segment_bytes;
            o_last              <= last_now;
        end
    end

    // Sequence scan, decide and fan-out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit_vld  <= 1'b0;
            r_free_vld <= 1'b0;
            r_n        <= '0;
            r_g        <= '0;
            r_status   <= STATUS_DONE;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_cmp_vld && r_valid[r_cmp_idx] && match) begin
                r_hit_vld <= 1'b1;
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx]) begin
                r_free_vld <= 1'b1;
            end
            if (ld) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    r_idx     <= '0;
                    if (o_q_pop) begin
                        r_hit_vld  <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_WAIT: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= S_DEC;
                end
                S_DEC: begin
                    r_g      <= '0;
                    r_status <= STATUS_DONE;
                    r_n      <= eff;
                    if (r_hit_vld) begin
                        if (new_cnt >= eff) begin
                            r_valid[r_hit_idx] <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (eff <= CNT_W'(1)) begin
                        r_state <= S_EMIT;
                    end else if (!r_free_vld) begin
                        r_status <= STATUS_FULL;
                        r_n      <= CNT_W'(1);
                        r_state  <= S_EMIT;
                    end else begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (ld) begin
                        r_g <= r_g + CNT_W'(1);
                        if (last_now) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_hit_vld) |-> r_valid[r_hit_idx])
        else $error("hit entry not valid at decide");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_g < r_n))
        else $error("fan-out counter past result count");
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && last_now) |=> (r_state == S_IDLE && r_out_vld && o_last))
        else $error("fan-out did not end on last beat");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_q_pop)
        else $error("queue popped while busy");

endmodule

FILE: hw/rtl/collective_segment_aggregator.sv
// Top level: configuration registers, front end and back end of the aggregator.
// Flow: the back end pops one kept header at a time from the front queue, scans the key
// table with one-entry-per-cycle reads, waits for the last registered read, decides, and
// loads each result beat of a fan-out into the result register, stalling while pop is low
// and a result waits; it pops no new header until done, and the front queue absorbs two.
// Reset: synchronous, active low; clears the table valid bits, queue pointers and state
// registers, sets the GPU count to 1 and clears the other configuration registers.
module collective_segment_aggregator
    import csa_pkg::*;
#(
    parameter int unsigned MAX_GPUS      = DEF_MAX_GPUS,
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_short_payload,
    input  logic [31:0] i_magic,
    input  logic [7:0]  i_kind,
    input  logic [7:0]  i_src_gpu,
    input  logic [31:0] i_group,
    input  logic [63:0] i_collective_id,
    input  logic [63:0] i_segment_id,
    input  logic [31:0] i_num_segments,
    input  logic [31:0] i_segment_bytes,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_status,
    output logic [2:0]  o_dest_gpu,
    output logic [15:0] o_source_node,
    output logic [31:0] o_group_out,
    output logic [63:0] o_collective_out,
    output logic [63:0] o_segment_out,
    output logic [31:0] o_num_segments_out,
    output logic [31:0] o_segment_bytes_out,
    output logic [15:0] o_switch_out,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [3:0]  r_num_gpu;
    logic [31:0] r_magic_word;
    logic [15:0] r_switch_id;
    logic [15:0] r_source_node_id;

    t_item in_item, q_item;
    logic  q_valid, q_pop;

    assign o_cfg_ready   = 1'b1;
    assign o_source_node = r_source_node_id;
    assign o_switch_out  = r_switch_id;

    assign in_item.src_gpu       = i_src_gpu;
    assign in_item.group         = i_group;
    assign in_item.collective_id = i_collective_id;
    assign in_item.segment_id    = i_segment_id;
    assign in_item.num_segments  = i_num_segments;
    assign in_item.segment_bytes = i_segment_bytes;

    // Take configuration beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_gpu        <= 4'd1;
            r_magic_word     <= '0;
            r_switch_id      <= '0;
            r_source_node_id <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_GPU:     r_num_gpu        <= i_cfg_data[3:0];
                CFG_MAGIC_WORD:  r_magic_word     <= i_cfg_data;
                CFG_SWITCH_ID:   r_switch_id      <= i_cfg_data[15:0];
                CFG_SOURCE_NODE: r_source_node_id <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    csa_front #(
        .MAX_GPUS (MAX_GPUS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_short_payload (i_short_payload),
        .i_magic         (i_magic),
        .i_kind          (i_kind),
        .i_item          (in_item),
        .i_num_gpu       (r_num_gpu),
        .i_magic_word    (r_magic_word),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    csa_back #(
        .MAX_GPUS      (MAX_GPUS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_num_gpu           (r_num_gpu),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_empty             (o_empty),
        .i_pop               (i_pop),
        .o_status            (o_status),
        .o_dest_gpu          (o_dest_gpu),
        .o_group_out         (o_group_out),
        .o_collective_out    (o_collective_out),
        .o_segment_out       (o_segment_out),
        .o_num_segments_out  (o_num_segments_out),
        .o_segment_bytes_out (o_segment_bytes_out),
        .o_last              (o_last)
    );

endmodule
